// File: design/cbc_pkg.sv
// shared constants, types and command/status bundles for the codebook conv layer
package cbc_pkg;

	localparam int MAX_IN_CHANNELS  = 64;
	localparam int MAX_OUT_CHANNELS = 64;
	localparam int MAX_LENGTH       = 128;
	localparam int KERNEL_TAPS      = 5;
	localparam int CODES_PER_WORD   = 8;
	localparam int CODEBOOK_SIZE    = 16;
	localparam int CODE_BITS        = 4;

	localparam int WEIGHT_CODES = MAX_IN_CHANNELS * MAX_OUT_CHANNELS * KERNEL_TAPS;
	localparam int WEIGHT_WORDS = (WEIGHT_CODES + CODES_PER_WORD - 1) / CODES_PER_WORD;
	localparam int BIAS_WORDS   = (MAX_OUT_CHANNELS + CODES_PER_WORD - 1) / CODES_PER_WORD;

	localparam int IC_W     = $clog2(MAX_IN_CHANNELS);
	localparam int OC_W     = $clog2(MAX_OUT_CHANNELS);
	localparam int POS_W    = $clog2(MAX_LENGTH);
	localparam int ICH_W    = $clog2(MAX_IN_CHANNELS + 1);
	localparam int OCH_W    = $clog2(MAX_OUT_CHANNELS + 1);
	localparam int LEN_W    = $clog2(MAX_LENGTH + 1);
	localparam int TAP_W    = $clog2(KERNEL_TAPS);
	localparam int CODE_W   = $clog2(WEIGHT_CODES);
	localparam int NIB_W    = $clog2(CODES_PER_WORD);
	localparam int WW_W     = CODE_W - NIB_W;
	localparam int BW_W     = OC_W - NIB_W;
	localparam int CB_W     = $clog2(CODEBOOK_SIZE);
	localparam int MAP_W    = 13;
	localparam int MAP_DEPTH = 2 ** MAP_W;
	localparam int IMAP_W   = IC_W + POS_W;
	localparam int OMAP_W   = OC_W + POS_W;
	localparam int DIV_W    = 16;

	// item modes
	localparam logic [2:0] MODE_WCB   = 3'd0;
	localparam logic [2:0] MODE_BCB   = 3'd1;
	localparam logic [2:0] MODE_WWORD = 3'd2;
	localparam logic [2:0] MODE_BWORD = 3'd3;
	localparam logic [2:0] MODE_INPUT = 3'd4;
	localparam logic [2:0] MODE_START = 3'd5;
	localparam logic [2:0] MODE_READ  = 3'd6;

	// register indexes
	localparam logic [1:0] REG_IN_CH  = 2'd0;
	localparam logic [1:0] REG_OUT_CH = 2'd1;
	localparam logic [1:0] REG_LEN    = 2'd2;
	localparam logic [1:0] REG_DIV    = 2'd3;

	typedef struct packed {
		logic [6:0]  in_ch;
		logic [6:0]  out_ch;
		logic [7:0]  len;
		logic [15:0] divisor;
	} cbc_cfg_t;

	typedef struct packed {
		logic              wr_en;
		logic [2:0]        wr_sel;
		logic [MAP_W-1:0]  wr_addr;
		logic [31:0]       wr_data;
		logic              omem_rd;
		logic [OMAP_W-1:0] rd_addr;
		logic              mac_issue;
		logic [WW_W-1:0]   w_word;
		logic [NIB_W-1:0]  w_nib;
		logic [IMAP_W-1:0] x_addr;
		logic              acc_clear;
		logic              bias_rd;
		logic [BW_W-1:0]   bias_word;
		logic              bias_latch;
		logic [NIB_W-1:0]  bias_nib;
		logic              sum_go;
		logic              div_start;
		logic [DIV_W-1:0]  divisor;
		logic              store;
		logic [OMAP_W-1:0] st_addr;
		logic              res_load;
		logic              res_rd;
		logic              res_status;
	} cbc_cmd_t;

	typedef struct packed {
		logic mac_busy;
		logic div_busy;
	} cbc_sts_t;

endpackage

// File: design/cbc_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module cbc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);
	import cbc_pkg::*;

	logic              busy_q;
	logic [4:0]        cnt_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dvs_q;
	logic [31:0]       quo_q;
	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    diff;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd31;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!diff[DIV_W]) begin
				rem_q <= diff[DIV_W-1:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// File: design/cbc_dp.sv
// datapath: codebooks, code word and map memories, mac pipeline, divider, result register
module cbc_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  cbc_pkg::cbc_cmd_t cmd,
	output cbc_pkg::cbc_sts_t sts,
	output logic [31:0]       read_data,
	output logic              status
);
	import cbc_pkg::*;

	logic [31:0] wcb_q [CODEBOOK_SIZE];
	logic [31:0] bcb_q [CODEBOOK_SIZE];
	logic [31:0] wmem [WEIGHT_WORDS];
	logic [31:0] bmem [BIAS_WORDS];
	logic [31:0] imem [MAP_DEPTH];
	logic [31:0] omem [MAP_DEPTH];

	logic              valid_s1, valid_s2;
	logic [31:0]       ww_s1, x_s1, prod_s2;
	logic [NIB_W-1:0]  nib_s1;
	logic [CB_W-1:0]   wcode;
	logic [31:0]       acc_q, bias_q, sum_q, bword_q, rd_q;
	logic              neg_q;
	logic [31:0]       quo;
	logic              div_busy;
	logic [31:0]       read_data_q;
	logic              status_q;

	// host writes
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			case (cmd.wr_sel)
				MODE_WCB:   wcb_q[cmd.wr_addr[CB_W-1:0]] <= cmd.wr_data;
				MODE_BCB:   bcb_q[cmd.wr_addr[CB_W-1:0]] <= cmd.wr_data;
				MODE_WWORD: wmem[cmd.wr_addr[WW_W-1:0]] <= cmd.wr_data;
				MODE_BWORD: bmem[cmd.wr_addr[BW_W-1:0]] <= cmd.wr_data;
				MODE_INPUT: imem[cmd.wr_addr[IMAP_W-1:0]] <= cmd.wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			omem[cmd.st_addr] <= neg_q ? 32'd0 : quo;
		end
		if (cmd.omem_rd) begin
			rd_q <= omem[cmd.rd_addr];
		end
	end

	// mac pipeline: memory read, decode and multiply, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.mac_issue;
			valid_s2 <= valid_s1;
		end
	end

	assign wcode = ww_s1[nib_s1*CODE_BITS +: CODE_BITS];

	always_ff @(posedge clk) begin
		if (cmd.mac_issue) begin
			ww_s1  <= wmem[cmd.w_word];
			x_s1   <= imem[cmd.x_addr];
			nib_s1 <= cmd.w_nib;
		end
		prod_s2 <= 32'(x_s1 * wcb_q[wcode]);
		if (cmd.acc_clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + prod_s2;
		end
		if (cmd.bias_rd) begin
			bword_q <= bmem[cmd.bias_word];
		end
		if (cmd.bias_latch) begin
			bias_q <= bcb_q[bword_q[cmd.bias_nib*CODE_BITS +: CODE_BITS]];
		end
		if (cmd.sum_go) begin
			sum_q <= acc_q + bias_q;
		end
		if (cmd.div_start) begin
			neg_q <= sum_q[31];
		end
	end

	cbc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (cmd.divisor),
		.busy     (div_busy),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			read_data_q <= cmd.res_rd ? rd_q : 32'd0;
			status_q    <= cmd.res_status;
		end
	end

	assign sts.mac_busy = valid_s1 | valid_s2;
	assign sts.div_busy = div_busy;
	assign read_data    = read_data_q;
	assign status       = status_q;

endmodule

// File: design/cbc_ctrl.sv
// controller: item decode, layer walk sequencer and result handshake
module cbc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [2:0]        mode,
	input  logic [12:0]       address,
	input  logic [31:0]       data,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  cbc_pkg::cbc_cfg_t cfg,
	input  cbc_pkg::cbc_sts_t sts,
	output cbc_pkg::cbc_cmd_t cmd
);
	import cbc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_BIAS1, S_BIAS2, S_MAC, S_DRAIN, S_SUM, S_DIVW, S_STORE, S_DONE
	} state_t;

	state_t             state_q;
	logic               m_valid_q;
	logic [OC_W-1:0]    oc_q;
	logic [IC_W-1:0]    ic_q;
	logic [POS_W-1:0]   p_q;
	logic [TAP_W-1:0]   t_q;
	logic [CODE_W-1:0]  n_q, base_q, nin5_q;
	logic [ICH_W-1:0]   nin_q;
	logic [OCH_W-1:0]   nout_q;
	logic [LEN_W-1:0]   olen_q;
	logic [DIV_W-1:0]   div_q;

	logic               accept;
	logic               in_range;
	logic               last_t, last_ic, last_p, last_oc;
	logic [ICH_W-1:0]   nin_c;
	logic [OCH_W-1:0]   nout_c;
	logic [LEN_W-1:0]   len_c;

	assign s_tready = (state_q == S_IDLE) && (!m_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;

	// clamp registers at start
	always_comb begin
		if (cfg.in_ch == 7'd0) nin_c = ICH_W'(1);
		else if (cfg.in_ch > 7'(MAX_IN_CHANNELS)) nin_c = ICH_W'(MAX_IN_CHANNELS);
		else nin_c = ICH_W'(cfg.in_ch);
		if (cfg.out_ch == 7'd0) nout_c = OCH_W'(1);
		else if (cfg.out_ch > 7'(MAX_OUT_CHANNELS)) nout_c = OCH_W'(MAX_OUT_CHANNELS);
		else nout_c = OCH_W'(cfg.out_ch);
		if (cfg.len < 8'(KERNEL_TAPS)) len_c = LEN_W'(KERNEL_TAPS);
		else if (cfg.len > 8'(MAX_LENGTH)) len_c = LEN_W'(MAX_LENGTH);
		else len_c = LEN_W'(cfg.len);
	end

	always_comb begin
		unique case (mode)
			MODE_WCB, MODE_BCB: in_range = address < 13'(CODEBOOK_SIZE);
			MODE_WWORD:         in_range = address < 13'(WEIGHT_WORDS);
			MODE_BWORD:         in_range = address < 13'(BIAS_WORDS);
			MODE_INPUT, MODE_START, MODE_READ: in_range = 1'b1;
			default:            in_range = 1'b0;
		endcase
	end

	assign last_t  = t_q == TAP_W'(KERNEL_TAPS - 1);
	assign last_ic = ic_q == IC_W'(nin_q - ICH_W'(1));
	assign last_p  = p_q == POS_W'(olen_q - LEN_W'(1));
	assign last_oc = oc_q == OC_W'(nout_q - OCH_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
			oc_q      <= '0;
			ic_q      <= '0;
			p_q       <= '0;
			t_q       <= '0;
			n_q       <= '0;
			base_q    <= '0;
			nin5_q    <= '0;
			nin_q     <= '0;
			nout_q    <= '0;
			olen_q    <= '0;
			div_q     <= '0;
		end else begin
			if (cmd.res_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && mode == MODE_START) begin
						nin_q  <= nin_c;
						nout_q <= nout_c;
						olen_q <= len_c - LEN_W'(KERNEL_TAPS - 1);
						div_q  <= (cfg.divisor == 16'd0) ? 16'd1 : cfg.divisor;
						nin5_q <= CODE_W'(nin_c) * CODE_W'(KERNEL_TAPS);
						oc_q   <= '0;
						ic_q   <= '0;
						p_q    <= '0;
						t_q    <= '0;
						n_q    <= '0;
						base_q <= '0;
						state_q <= S_BIAS1;
					end else if (accept && mode == MODE_READ) begin
						state_q <= S_READ;
					end
				end
				S_READ:  state_q <= S_IDLE;
				S_BIAS1: state_q <= S_BIAS2;
				S_BIAS2: state_q <= S_MAC;
				S_MAC: begin
					n_q <= n_q + CODE_W'(1);
					if (last_t) begin
						t_q <= '0;
						if (last_ic) begin
							state_q <= S_DRAIN;
						end else begin
							ic_q <= ic_q + IC_W'(1);
						end
					end else begin
						t_q <= t_q + TAP_W'(1);
					end
				end
				S_DRAIN: begin
					if (!sts.mac_busy) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: state_q <= S_DIVW;
				S_DIVW: begin
					if (!sts.div_busy) begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					ic_q <= '0;
					t_q  <= '0;
					if (last_p) begin
						p_q <= '0;
						if (last_oc) begin
							state_q <= S_DONE;
						end else begin
							oc_q    <= oc_q + OC_W'(1);
							base_q  <= base_q + nin5_q;
							n_q     <= base_q + nin5_q;
							state_q <= S_BIAS1;
						end
					end else begin
						p_q     <= p_q + POS_W'(1);
						n_q     <= base_q;
						state_q <= S_MAC;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.wr_sel     = mode;
		cmd.wr_addr    = address;
		cmd.wr_data    = data;
		cmd.rd_addr    = address[OMAP_W-1:0];
		cmd.w_word     = n_q[CODE_W-1:NIB_W];
		cmd.w_nib      = n_q[NIB_W-1:0];
		cmd.x_addr     = {ic_q, POS_W'(p_q + POS_W'(t_q))};
		cmd.bias_word  = oc_q[OC_W-1:NIB_W];
		cmd.bias_nib   = oc_q[NIB_W-1:0];
		cmd.divisor    = div_q;
		cmd.st_addr    = {oc_q, p_q};
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.wr_en      = in_range && mode != MODE_START && mode != MODE_READ;
					cmd.omem_rd    = mode == MODE_READ;
					cmd.res_load   = mode != MODE_START && mode != MODE_READ;
					cmd.res_status = !in_range;
				end
			end
			S_READ: begin
				cmd.res_load = 1'b1;
				cmd.res_rd   = 1'b1;
			end
			S_BIAS1: cmd.bias_rd = 1'b1;
			S_BIAS2: begin
				cmd.bias_latch = 1'b1;
				cmd.acc_clear  = 1'b1;
			end
			S_MAC:   cmd.mac_issue = 1'b1;
			S_DRAIN: cmd.sum_go = !sts.mac_busy;
			S_SUM:   cmd.div_start = 1'b1;
			S_DIVW:  ;
			S_STORE: begin
				cmd.store     = 1'b1;
				cmd.acc_clear = 1'b1;
			end
			S_DONE:  cmd.res_load = 1'b1;
			default: ;
		endcase
	end

	a_res_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!m_valid_q || m_tready))
		else $error("result register overwritten");
	a_clear_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc_clear |-> !sts.mac_busy)
		else $error("accumulator cleared with products in flight");
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider restarted while busy");
	a_store_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> !sts.div_busy && $past(state_q == S_DIVW))
		else $error("store before quotient ready");

endmodule

// File: design/codebook_conv1d_relu_layer_top.sv
// top level: stream ports, register port and controller/datapath wiring
// load and unused-mode beats: result registered in the cycle after accept, one beat per cycle while m_tready is high
// read beats: the word is read into rd_q, then loaded into the result register; no new beat is taken meanwhile
// start: the layer walk is paced by the single mac pipeline (one product per cycle)
//   and the bit-serial divider, which runs once per output value
// reset clears control state and sets the config registers to their defaults; memories are undefined until written
module codebook_conv1d_relu_layer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // address[12:0], data[44:13], zero pad
	input  logic [2:0]  s_tuser,   // mode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // read_data[31:0]
	output logic        m_tuser,   // status[0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cbc_pkg::*;

	cbc_cfg_t cfg_q;
	cbc_cmd_t cmd;
	cbc_sts_t sts;
	logic     cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_ch   <= 7'd64;
			cfg_q.out_ch  <= 7'd64;
			cfg_q.len     <= 8'd116;
			cfg_q.divisor <= 16'd1000;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_IN_CH:  cfg_q.in_ch   <= pwdata[6:0];
				REG_OUT_CH: cfg_q.out_ch  <= pwdata[6:0];
				REG_LEN:    cfg_q.len     <= pwdata[7:0];
				REG_DIV:    cfg_q.divisor <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_IN_CH:  prdata = {25'd0, cfg_q.in_ch};
			REG_OUT_CH: prdata = {25'd0, cfg_q.out_ch};
			REG_LEN:    prdata = {24'd0, cfg_q.len};
			REG_DIV:    prdata = {16'd0, cfg_q.divisor};
			default:    prdata = 32'd0;
		endcase
	end

	cbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.mode     (s_tuser),
		.address  (s_tdata[12:0]),
		.data     (s_tdata[44:13]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg      (cfg_q),
		.sts      (sts),
		.cmd      (cmd)
	);

	cbc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.read_data (m_tdata),
		.status    (m_tuser)
	);

endmodule

// File: test/testbench.sv
// testbench for the codebook conv1d relu layer: stream beats, register writes, checked reads
`timescale 1ns / 100ps

module testbench;
	import cbc_pkg::*;

	localparam logic [2:0] MODE_UNUSED = 3'd7;

	typedef struct {
		logic [2:0]  mode;
		logic [12:0] addr;
		logic [31:0] data;
	} beat_t;

	typedef struct {
		logic [31:0] read_data;
		logic        status;
	} response_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // address[12:0], data[44:13], zero pad
	logic [2:0]  s_tuser = '0;   // mode[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // read_data[31:0]
	logic        m_tuser;        // status[0]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	codebook_conv1d_relu_layer_top u_top (.*);

	// layer state as the block should hold it
	logic [6:0]  cfg_in_ch, cfg_out_ch;
	logic [7:0]  cfg_len;
	logic [15:0] cfg_div;
	logic [31:0] wbook [CODEBOOK_SIZE];
	logic [31:0] bbook [CODEBOOK_SIZE];
	logic [31:0] wwords [WEIGHT_WORDS];
	logic [31:0] bwords [BIAS_WORDS];
	logic [31:0] in_map [MAP_DEPTH];
	logic [31:0] out_map [MAP_DEPTH];

	// what the stimulus has already loaded or produced
	bit wword_loaded [WEIGHT_WORDS];
	bit bword_loaded [BIAS_WORDS];
	bit in_loaded [MAP_DEPTH];
	bit out_made [MAP_DEPTH];

	beat_t     pending_beats [$];
	response_t expected_responses [$];
	beat_t     cur;
	bit        took = 0;
	int        queued_cnt = 0;
	int        accepted_cnt = 0;
	int        errors = 0;
	int        send_idle = 0;
	int        recv_stall = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("FAIL codebook_conv1d_relu_layer_top");
		$finish;
	end

	function automatic void layer_dims(output int nin, output int nout, output int len);
		nin  = (cfg_in_ch == 0) ? 1 : (cfg_in_ch > MAX_IN_CHANNELS) ? MAX_IN_CHANNELS : cfg_in_ch;
		nout = (cfg_out_ch == 0) ? 1 :
			(cfg_out_ch > MAX_OUT_CHANNELS) ? MAX_OUT_CHANNELS : cfg_out_ch;
		len  = (cfg_len < KERNEL_TAPS) ? KERNEL_TAPS : (cfg_len > MAX_LENGTH) ? MAX_LENGTH : cfg_len;
	endfunction

	function automatic logic [3:0] code_of(input logic [31:0] word, input int n);
		return word[(n % CODES_PER_WORD) * CODE_BITS +: CODE_BITS];
	endfunction

	function automatic void compute_feature_map();
		int nin, nout, len, n;
		logic [31:0] acc, bias, w, dv;
		layer_dims(nin, nout, len);
		dv = (cfg_div == 0) ? 32'd1 : {16'd0, cfg_div};
		for (int oc = 0; oc < nout; oc++) begin
			bias = bbook[code_of(bwords[oc / CODES_PER_WORD], oc)];
			for (int p = 0; p <= len - KERNEL_TAPS; p++) begin
				acc = 0;
				for (int ic = 0; ic < nin; ic++)
					for (int t = 0; t < KERNEL_TAPS; t++) begin
						n = t + ic * KERNEL_TAPS + oc * nin * KERNEL_TAPS;
						w = wbook[code_of(wwords[n / CODES_PER_WORD], n)];
						acc = acc + in_map[ic * MAX_LENGTH + p + t] * w;
					end
				acc = acc + bias;
				out_map[oc * MAX_LENGTH + p] = (acc[31] || acc < dv) ? 32'd0 : acc / dv;
			end
		end
	endfunction

	function automatic void predict_response(input beat_t b);
		response_t r;
		r.read_data = 0;
		r.status = 0;
		case (b.mode)
			MODE_WCB: if (b.addr < CODEBOOK_SIZE) wbook[b.addr] = b.data; else r.status = 1;
			MODE_BCB: if (b.addr < CODEBOOK_SIZE) bbook[b.addr] = b.data; else r.status = 1;
			MODE_WWORD: if (b.addr < WEIGHT_WORDS) wwords[b.addr] = b.data; else r.status = 1;
			MODE_BWORD: if (b.addr < BIAS_WORDS) bwords[b.addr] = b.data; else r.status = 1;
			MODE_INPUT: in_map[b.addr] = b.data;
			MODE_START: compute_feature_map();
			MODE_READ: r.read_data = out_map[b.addr];
			default: r.status = 1;
		endcase
		expected_responses.push_back(r);
	endfunction

	// monitor: accept detection and response check
	always @(posedge clk) begin
		response_t e;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_response(cur);
				took = 1;
				accepted_cnt++;
			end
			if (m_tvalid && m_tready) begin
				if (expected_responses.size() == 0) begin
					$display("%t unexpected beat: read_data %h status %b", $realtime, m_tdata, m_tuser);
					errors++;
				end else begin
					e = expected_responses.pop_front();
					if (m_tdata !== e.read_data) begin
						$display("%t read_data mismatch: expected %h actual %h",
							$realtime, e.read_data, m_tdata);
						errors++;
					end
					if (m_tuser !== e.status) begin
						$display("%t status mismatch: expected %b actual %b",
							$realtime, e.status, m_tuser);
						errors++;
					end
				end
			end
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || took) begin
				took = 0;
				if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle) begin
					cur = pending_beats.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {3'b000, cur.data, cur.addr};
					s_tuser <= cur.mode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic send(input logic [2:0] mode, input int addr, input logic [31:0] data);
		beat_t b;
		b.mode = mode;
		b.addr = addr[12:0];
		b.data = data;
		pending_beats.push_back(b);
		queued_cnt++;
		if (mode == MODE_WWORD && addr < WEIGHT_WORDS) wword_loaded[addr] = 1;
		if (mode == MODE_BWORD && addr < BIAS_WORDS) bword_loaded[addr] = 1;
		if (mode == MODE_INPUT) in_loaded[addr] = 1;
	endtask

	task automatic drain();
		while (accepted_cnt != queued_cnt || expected_responses.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_IN_CH: cfg_in_ch = value[6:0];
			REG_OUT_CH: cfg_out_ch = value[6:0];
			REG_LEN: cfg_len = value[7:0];
			default: cfg_div = value[15:0];
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_layer(input int nin, input int nout, input int len, input int dv);
		reg_write(REG_IN_CH, {$urandom} & ~32'h7f | nin);
		reg_write(REG_OUT_CH, {$urandom} & ~32'h7f | nout);
		reg_write(REG_LEN, {$urandom} & ~32'hff | len);
		reg_write(REG_DIV, {$urandom} & ~32'hffff | dv);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(200) - 100;
			2: case ($urandom_range(4))
				0: return 32'h0;
				1: return 32'h1;
				2: return 32'h7fffffff;
				3: return 32'h80000000;
				default: return 32'hffffffff;
			endcase
			default: return $urandom_range(1000);
		endcase
	endfunction

	// load the weight words, bias words and input values the current layer size still lacks, then start it
	task automatic start_layer();
		int nin, nout, len;
		layer_dims(nin, nout, len);
		for (int i = 0; i <= (nin * nout * KERNEL_TAPS - 1) / CODES_PER_WORD; i++)
			if (!wword_loaded[i]) send(MODE_WWORD, i, $urandom);
		for (int i = 0; i <= (nout - 1) / CODES_PER_WORD; i++)
			if (!bword_loaded[i]) send(MODE_BWORD, i, $urandom);
		for (int ic = 0; ic < nin; ic++)
			for (int p = 0; p < len; p++)
				if (!in_loaded[ic * MAX_LENGTH + p])
					send(MODE_INPUT, ic * MAX_LENGTH + p, pick_value());
		send(MODE_START, $urandom_range(8191), $urandom);
		for (int oc = 0; oc < nout; oc++)
			for (int p = 0; p <= len - KERNEL_TAPS; p++)
				out_made[oc * MAX_LENGTH + p] = 1;
	endtask

	task automatic read_outputs(input int count);
		int nin, nout, len, a;
		layer_dims(nin, nout, len);
		send(MODE_READ, (nout - 1) * MAX_LENGTH + len - KERNEL_TAPS, $urandom);
		for (int i = 1; i < count; i++) begin
			a = $urandom_range(nout - 1) * MAX_LENGTH + $urandom_range(len - KERNEL_TAPS);
			send(MODE_READ, a, $urandom);
		end
	endtask

	task automatic noise_beat();
		case ($urandom_range(3))
			0: send(MODE_UNUSED, $urandom_range(8191), $urandom);
			1: send(3'($urandom_range(1)), $urandom_range(8191, CODEBOOK_SIZE), $urandom);
			2: send(MODE_WWORD, $urandom_range(8191, WEIGHT_WORDS), $urandom);
			default: send(MODE_BWORD, $urandom_range(8191, BIAS_WORDS), $urandom);
		endcase
	endtask

	initial begin
		int nin, nout, len, phase, k;
		cfg_in_ch = 64;
		cfg_out_ch = 64;
		cfg_len = 116;
		cfg_div = 1000;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: smallest layer, codebooks with extreme values, every rejected case
		set_layer(1, 1, 5, 1);
		send(MODE_WCB, 0, 32'h7fffffff);
		send(MODE_WCB, 1, 32'h80000000);
		send(MODE_WCB, 2, 32'hffffffff);
		send(MODE_WCB, 3, 32'h0);
		for (int i = 4; i < CODEBOOK_SIZE; i++) send(MODE_WCB, i, pick_value());
		send(MODE_BCB, 0, 32'h80000000);
		send(MODE_BCB, 15, 32'h7fffffff);
		for (int i = 1; i < CODEBOOK_SIZE - 1; i++) send(MODE_BCB, i, pick_value());
		send(MODE_UNUSED, 13'h1fff, 32'hffffffff);
		send(MODE_WCB, 8191, 32'h1);
		send(MODE_BCB, CODEBOOK_SIZE, 32'h1);
		send(MODE_WWORD, WEIGHT_WORDS, 32'h1);
		send(MODE_BWORD, BIAS_WORDS, 32'h1);
		send(MODE_INPUT, 8191, 32'hffffffff);
		send(MODE_INPUT, 0, 32'h7fffffff);
		start_layer();
		read_outputs(2);
		drain();

		// extreme register settings, out-of-range values saturate
		set_layer(127, 1, 5, 65535);
		start_layer();
		read_outputs(2);
		drain();
		set_layer(1, 127, 0, 0);
		start_layer();
		read_outputs(3);
		drain();
		set_layer(0, 0, 255, 3);
		start_layer();
		read_outputs(3);
		drain();
		set_layer(2, 64, 5, 1);
		start_layer();
		read_outputs(3);
		drain();

		// random layers with random content, one layer per idling phase
		phase = 0;
		while (phase < 4) begin
			case (phase % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 82; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 82; end
				default: begin send_idle = 24; recv_stall = 24; end
			endcase
			case ($urandom_range(3))
				0: k = 1;
				1: k = 65535;
				2: k = $urandom_range(100);
				default: k = $urandom_range(65535);
			endcase
			set_layer($urandom_range(4, 1), $urandom_range(4, 1), $urandom_range(16, 5), k);
			layer_dims(nin, nout, len);
			for (int i = 0; i < 20; i++) begin
				case ($urandom_range(9))
					0: send(MODE_WCB, $urandom_range(CODEBOOK_SIZE - 1), pick_value());
					1: send(MODE_BCB, $urandom_range(CODEBOOK_SIZE - 1), pick_value());
					2, 3: send(MODE_WWORD,
						$urandom_range((nin * nout * KERNEL_TAPS - 1) / CODES_PER_WORD), $urandom);
					4: send(MODE_BWORD, $urandom_range((nout - 1) / CODES_PER_WORD), $urandom);
					5, 6, 7: send(MODE_INPUT,
						$urandom_range(nin - 1) * MAX_LENGTH + $urandom_range(len - 1),
						pick_value());
					8: noise_beat();
					default: begin
						k = $urandom_range(8191);
						if (out_made[k]) send(MODE_READ, k, $urandom);
						else send(MODE_INPUT, k, pick_value());
					end
				endcase
			end
			start_layer();
			read_outputs(12);
			drain();
			phase++;
		end

		send_idle = 0;
		recv_stall = 0;
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASS codebook_conv1d_relu_layer_top");
		else
			$display("FAIL codebook_conv1d_relu_layer_top");
		$finish;
	end

endmodule

// File: sim.f
design/cbc_pkg.sv
design/cbc_div.sv
design/cbc_dp.sv
design/cbc_ctrl.sv
design/codebook_conv1d_relu_layer_top.sv
test/testbench.sv
